// ----- hdl/pwd_pkg.sv -----
package pwd_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int SEG_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int COORD_W      = 32;
    localparam int SPACING_W    = 31;
    localparam int MAG_W        = COORD_W + 1;
    localparam int ROOT_W       = 34;
    localparam int RAD_W        = 2 * ROOT_W;
    localparam int REM_W        = ROOT_W + 3;
    localparam int ACC_W        = SPACING_W + SEG_W;
    localparam int AXES         = 3;

    typedef struct packed {
        logic       load;
        logic       sq_step;
        logic [1:0] sq_sel;
        logic       root_step;
        logic       seg_init;
        logic       seg_step;
        logic       set_clamp;
        logic       div_init;
        logic       div_step;
        logic       emit_mid;
        logic       emit_last;
    } pwd_cmd_t;

    typedef struct packed {
        logic             no_subdiv;
        logic             root_gt;
        logic             seg_hit;
        logic             seg_max;
        logic [SEG_W-1:0] seg;
        logic             out_free;
    } pwd_status_t;

endpackage

// ----- hdl/pwd_ctrl.sv -----
module pwd_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tuser_first,
    output logic                 s_tready,
    output pwd_pkg::pwd_cmd_t    cmd,
    input  pwd_pkg::pwd_status_t status
);
    import pwd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SQ, ST_ROOT, ST_CMP, ST_SEG, ST_DIV, ST_MID, ST_LAST
    } state_t;

    localparam logic [5:0] SQ_END   = 6'(AXES - 1);
    localparam logic [5:0] ROOT_END = 6'(ROOT_W - 1);
    localparam logic [5:0] DIV_END  = 6'(MAG_W - 1);

    state_t     state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [SEG_W-1:0] seg_m1;

    assign s_tready = (state_reg == ST_IDLE);
    assign seg_m1   = status.seg - SEG_W'(1);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    // first point or spacing zero: corner alone
                    if (s_tuser_first || status.no_subdiv) state_next = ST_LAST;
                    else state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                cmd.sq_step = 1'b1;
                cmd.sq_sel  = cnt_reg[1:0];
                cnt_next    = cnt_reg + 6'd1;
                if (cnt_reg == SQ_END) begin
                    cnt_next   = '0;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg + 6'd1;
                if (cnt_reg == ROOT_END) state_next = ST_CMP;
            end
            ST_CMP: begin
                if (status.root_gt) begin
                    cmd.seg_init = 1'b1;
                    state_next   = ST_SEG;
                end else begin
                    state_next = ST_LAST;
                end
            end
            ST_SEG: begin
                cnt_next = '0;
                if (status.seg_hit) begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end else if (status.seg_max) begin
                    cmd.set_clamp = 1'b1;
                    cmd.div_init  = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    cmd.seg_step = 1'b1;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == DIV_END) begin
                    cnt_next   = 6'd1;
                    state_next = ST_MID;
                end
            end
            ST_MID: begin
                if (status.out_free) begin
                    cmd.emit_mid = 1'b1;
                    cnt_next     = cnt_reg + 6'd1;
                    if (cnt_reg == seg_m1[5:0]) state_next = ST_LAST;
                end
            end
            ST_LAST: begin
                if (status.out_free) begin
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ----- hdl/pwd_datapath.sv -----
module pwd_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic [pwd_pkg::SPACING_W-1:0] cfg_data,
    input  logic [95:0]                   s_tdata,
    input  pwd_pkg::pwd_cmd_t             cmd,
    output pwd_pkg::pwd_status_t          status,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [95:0]                   m_tdata,
    output logic                          m_tlast,
    output logic [0:0]                    m_tuser
);
    import pwd_pkg::*;

    logic [SPACING_W-1:0]              spacing_reg;
    logic [AXES-1:0][COORD_W-1:0]      prev_reg, cur_reg;
    logic [AXES-1:0][MAG_W-1:0]        mag_reg;   // |delta|, then quotient
    logic [AXES-1:0]                   neg_reg;
    logic [AXES-1:0][SEG_W-1:0]        rm_reg;    // |delta| mod segs
    logic [AXES-1:0][MAG_W-1:0]        q_reg;
    logic [AXES-1:0][SEG_W-1:0]        r_reg;
    logic [RAD_W-1:0]                  rad_reg;
    logic [REM_W-1:0]                  rem_reg;
    logic [ROOT_W-1:0]                 root_reg;
    logic [ACC_W-1:0]                  acc_reg;
    logic [SEG_W-1:0]                  seg_reg;
    logic                              clamp_reg;
    logic                              m_tvalid_reg;
    logic [95:0]                       m_tdata_reg;
    logic                              m_tlast_reg;
    logic                              m_tuser_reg;

    logic [MAG_W-1:0]     sq_op;
    logic [2*MAG_W-1:0]   sq_prod;
    logic [REM_W-1:0]     rem_sh, trial;
    logic                 out_free;

    logic [AXES-1:0][MAG_W-1:0]   dlt;
    logic [AXES-1:0][SEG_W-1:0]   dr_sh;
    logic [AXES-1:0]              dq_bit;
    logic [AXES-1:0][SEG_W:0]     rsum;
    logic [AXES-1:0]              rcarry;
    logic [AXES-1:0][MAG_W-1:0]   q_nx;
    logic [AXES-1:0][SEG_W-1:0]   r_nx;
    logic [AXES-1:0][COORD_W-1:0] mid_pt;

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            dlt[a]    = {s_tdata[a*COORD_W+COORD_W-1], s_tdata[a*COORD_W +: COORD_W]}
                      - {prev_reg[a][COORD_W-1], prev_reg[a]};
            dr_sh[a]  = {rm_reg[a][SEG_W-2:0], mag_reg[a][MAG_W-1]};
            dq_bit[a] = (dr_sh[a] >= seg_reg);
            rsum[a]   = {1'b0, r_reg[a]} + {1'b0, rm_reg[a]};
            rcarry[a] = (rsum[a] >= {1'b0, seg_reg});
            q_nx[a]   = q_reg[a] + mag_reg[a] + MAG_W'(rcarry[a]);
            r_nx[a]   = rcarry[a] ? SEG_W'(rsum[a] - {1'b0, seg_reg}) : rsum[a][SEG_W-1:0];
            mid_pt[a] = neg_reg[a] ? prev_reg[a] - q_nx[a][COORD_W-1:0]
                                   : prev_reg[a] + q_nx[a][COORD_W-1:0];
        end
    end

    assign sq_op   = mag_reg[cmd.sq_sel];
    assign sq_prod = sq_op * sq_op;
    assign rem_sh  = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign out_free = !m_tvalid_reg || m_tready;

    assign status.no_subdiv = (spacing_reg == '0);
    assign status.root_gt   = (root_reg > ROOT_W'(spacing_reg));
    assign status.seg_hit   = (acc_reg >= ACC_W'(root_reg));
    assign status.seg_max   = (seg_reg == SEG_W'(MAX_SEGMENTS));
    assign status.seg       = seg_reg;
    assign status.out_free  = out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spacing_reg  <= '0;
            prev_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) spacing_reg <= cfg_data;
            if (cmd.emit_last) prev_reg <= cur_reg;
            if (cmd.emit_mid || cmd.emit_last) m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int a = 0; a < AXES; a++) begin
                cur_reg[a] <= s_tdata[a*COORD_W +: COORD_W];
                neg_reg[a] <= dlt[a][MAG_W-1];
                mag_reg[a] <= dlt[a][MAG_W-1] ? -dlt[a] : dlt[a];
            end
            rad_reg   <= '0;
            rem_reg   <= '0;
            root_reg  <= '0;
            clamp_reg <= 1'b0;
        end
        if (cmd.sq_step) rad_reg <= rad_reg + RAD_W'(sq_prod);
        if (cmd.root_step) begin
            rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
        if (cmd.seg_init) begin
            acc_reg <= ACC_W'(spacing_reg);
            seg_reg <= SEG_W'(1);
        end
        if (cmd.seg_step) begin
            acc_reg <= acc_reg + ACC_W'(spacing_reg);
            seg_reg <= seg_reg + SEG_W'(1);
        end
        if (cmd.set_clamp) clamp_reg <= 1'b1;
        // r_reg starts interpolation at zero
        if (cmd.div_init) begin
            r_reg  <= '0;
            q_reg  <= '0;
            rm_reg <= '0;
        end
        // restoring division of |delta| by segs; quotient shifts into mag_reg
        if (cmd.div_step) begin
            for (int a = 0; a < AXES; a++) begin
                mag_reg[a] <= {mag_reg[a][MAG_W-2:0], dq_bit[a]};
                rm_reg[a]  <= dq_bit[a] ? dr_sh[a] - seg_reg : dr_sh[a];
            end
        end
        if (cmd.emit_mid) begin
            for (int a = 0; a < AXES; a++) begin
                q_reg[a] <= q_nx[a];
                r_reg[a] <= r_nx[a];
            end
            m_tdata_reg <= {mid_pt[2], mid_pt[1], mid_pt[0]};
            m_tlast_reg <= 1'b0;
            m_tuser_reg <= clamp_reg;
        end
        if (cmd.emit_last) begin
            m_tdata_reg <= {cur_reg[2], cur_reg[1], cur_reg[0]};
            m_tlast_reg <= 1'b1;
            m_tuser_reg <= clamp_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tlast    = m_tlast_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

// ----- hdl/path_waypoint_densifier.sv -----
// Channel | Beat payload                                  | Handshake
// s_      | tdata x,y,z (32b signed Q.8), tuser first      | s_tvalid/s_tready
// m_      | tdata x,y,z (32b signed Q.8), tlast, tuser clamp| m_tvalid/m_tready
// cfg_    | data spacing (31b unsigned)                    | cfg_valid/cfg_ready
//
// One corner at a time. A first point or spacing zero: load, then its beat.
// Otherwise: 1 load + 3 squares (one shared 33x33 multiplier) + 34 square-root
// steps + 1 compare, then a linear segment search of up to 64 segments, 33
// divider steps, and one waypoint beat per cycle while m_ is not stalled.
// Reset (aresetn low, synchronous) clears prev corner, spacing and valids.
// A stalled m_ side holds the output register; s_tready is low while busy.
module path_waypoint_densifier (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // point_x, point_y, point_z
    input  logic [0:0]  s_tuser,   // first_point
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // out_x, out_y, out_z
    output logic        m_tlast,   // last_of_run
    output logic [0:0]  m_tuser,   // clamped
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [30:0] cfg_data   // spacing
);
    import pwd_pkg::*;

    pwd_cmd_t    cmd;
    pwd_status_t status;

    assign cfg_ready = 1'b1;

    pwd_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tuser_first (s_tuser[0]),
        .s_tready      (s_tready),
        .cmd           (cmd),
        .status        (status)
    );

    pwd_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

// ----- hdl/pwd_checker.sv -----
module pwd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic        m_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while corner in progress");

    a_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready before run finished");

    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");
endmodule

bind path_waypoint_densifier pwd_checker u_pwd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ----- tb/path_waypoint_densifier_tb.sv -----
`timescale 1ns / 1ps

module path_waypoint_densifier_tb;
    import pwd_pkg::*;

    // waypoint as seen on the m_ side
    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        last;
        logic        clamp;
    } waypoint_t;

    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 300;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;   // point_x, point_y, point_z
    logic [0:0]  s_tuser;   // first_point
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;   // out_x, out_y, out_z
    logic        m_tlast;   // last_of_run
    logic [0:0]  m_tuser;   // clamped
    logic        cfg_valid;
    logic        cfg_ready;
    logic [30:0] cfg_data;  // spacing

    path_waypoint_densifier u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // predictor state
    logic signed [31:0] corner_x, corner_y, corner_z;
    logic [30:0]        spacing_q;
    waypoint_t          waypoint_q[$];

    int  errors;
    int  beats_in;
    int  beats_out;
    int  clamp_runs;
    int  idle_cycles;
    bit  sink_stall_en;
    bit  src_stall_en;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // floor sqrt of a 68-bit value, bitwise
    function automatic logic [33:0] floor_root(logic [67:0] n);
        logic [33:0] r;
        logic [33:0] t;
        r = '0;
        for (int b = 33; b >= 0; b--) begin
            t = r | (34'd1 << b);
            if ({34'd0, t} * {34'd0, t} <= n) r = t;
        end
        return r;
    endfunction

    // prev + delta*j/segs, quotient truncated toward zero
    function automatic logic [31:0] lerp_axis(logic signed [31:0] base,
                                              logic signed [32:0] delta,
                                              int j, int segs);
        logic [32:0] m;
        logic [39:0] q;
        logic signed [40:0] step;
        m = delta[32] ? -delta : delta;
        q = ({7'd0, m} * 40'(j)) / 40'(segs);
        step = delta[32] ? -$signed({1'b0, q}) : $signed({1'b0, q});
        return 32'($signed(base) + step);
    endfunction

    task automatic expect_waypoint(waypoint_t w);
        waypoint_q = {waypoint_q, w};
    endtask

    task automatic predict_corner(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                  bit first);
        logic signed [32:0] dx, dy, dz;
        logic [32:0]        mx, my, mz;
        logic [67:0]        sum;
        logic [33:0]        d;
        logic [34:0]        segs_w;
        int                 segs;
        bit                 clamp;
        waypoint_t          w;
        clamp = 0;
        if (!first && spacing_q != 0) begin
            dx = $signed(px) - corner_x;
            dy = $signed(py) - corner_y;
            dz = $signed(pz) - corner_z;
            mx = dx[32] ? -dx : dx;
            my = dy[32] ? -dy : dy;
            mz = dz[32] ? -dz : dz;
            sum = {35'd0, mx} * {35'd0, mx} + {35'd0, my} * {35'd0, my}
                + {35'd0, mz} * {35'd0, mz};
            d = floor_root(sum);
            if (d > {3'd0, spacing_q}) begin
                segs_w = ({1'b0, d} + {4'd0, spacing_q} - 35'd1) / {4'd0, spacing_q};
                if (segs_w > MAX_SEGMENTS) begin
                    segs = MAX_SEGMENTS;
                    clamp = 1;
                    clamp_runs++;
                end else begin
                    segs = int'(segs_w);
                end
                for (int j = 1; j < segs; j++) begin
                    w.x = lerp_axis(corner_x, dx, j, segs);
                    w.y = lerp_axis(corner_y, dy, j, segs);
                    w.z = lerp_axis(corner_z, dz, j, segs);
                    w.last = 0;
                    w.clamp = clamp;
                    expect_waypoint(w);
                end
            end
        end
        w.x = px; w.y = py; w.z = pz; w.last = 1; w.clamp = clamp;
        expect_waypoint(w);
        corner_x = px; corner_y = py; corner_z = pz;
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH beat %0d %s: got %h want %h", beats_out, what, got, want);
        errors++;
    endtask

    // result checker and sink-side stalls
    initial begin
        waypoint_t w;
        int stall;
        m_tready = 1'b0;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (waypoint_q.size() == 0) begin
                    $display("MISMATCH beat %0d: unexpected waypoint", beats_out);
                    errors++;
                end else begin
                    w = waypoint_q.pop_front();
                    if (m_tdata[31:0] !== w.x) report_mismatch("x", m_tdata[31:0], w.x);
                    if (m_tdata[63:32] !== w.y) report_mismatch("y", m_tdata[63:32], w.y);
                    if (m_tdata[95:64] !== w.z) report_mismatch("z", m_tdata[95:64], w.z);
                    if (m_tlast !== w.last)
                        report_mismatch("tlast", 32'(m_tlast), 32'(w.last));
                    if (m_tuser[0] !== w.clamp)
                        report_mismatch("clamp", 32'(m_tuser), 32'(w.clamp));
                end
                beats_out++;
            end
            if (stall > 0) stall--;
            else if (sink_stall_en && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 15);
            m_tready <= (stall == 0);
        end
    end

    // watchdog: cycles with no beat on any channel
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
                $display("path_waypoint_densifier test failed");
                $finish;
            end
        end
    end

    // the block is busy after it takes a beat, so s_tready is low at the first wait edge
    task automatic send_corner(logic [31:0] px, logic [31:0] py, logic [31:0] pz, bit first);
        @(posedge aclk);
        if (src_stall_en && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {pz, py, px};
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
        predict_corner(px, py, pz, first);
        beats_in++;
        s_tvalid <= 1'b0;
    endtask

    task automatic drain_waypoints();
        while (waypoint_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_spacing(logic [30:0] value);
        drain_waypoints();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        spacing_q = value;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 8000)) - 4000);
            default: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
        endcase
    endfunction

    // spacing zero at reset: pass-through, no first point since reset
    task automatic test_passthrough();
        send_corner(32'h0000_1000, 32'hFFFF_F000, 32'h7FFF_FFFF, 0);
        send_corner(32'h8000_0000, 32'h0, 32'h1, 0);
        send_corner(32'h1234_5678, 32'h8765_4321, 32'h0, 1);
    endtask

    task automatic test_directed();
        write_spacing(31'd256);
        send_corner(32'd0, 32'd0, 32'd0, 1);
        send_corner(32'd1000, 32'd0, 32'd0, 0);          // 4 segments
        send_corner(32'd1000, 32'd256, 32'd0, 0);        // exactly spacing
        send_corner(32'($signed(-2000)), 32'd500, 32'($signed(-700)), 0);
        send_corner(32'd1000, 32'd0, 32'd0, 1);
        write_spacing(31'd1);
        send_corner(32'd0, 32'd0, 32'd0, 0);             // clamp
        write_spacing(31'h7FFF_FFFF);
        send_corner(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1);
        send_corner(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0); // largest delta
        send_corner(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        write_spacing(31'd1);
        send_corner(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        write_spacing(31'd100);
        send_corner(32'd101, 32'd0, 32'd0, 1);
        send_corner(32'd0, 32'd0, 32'd0, 0);             // d just over spacing
        send_corner(32'd0, 32'd0, 32'd6400, 0);          // exactly 64 segments
        send_corner(32'd0, 32'd0, 32'd0, 0);
        send_corner(32'd0, 32'd0, 32'd6401, 0);          // 65 -> clamp
    endtask

    task automatic test_random_paths(int count);
        int sent;
        int mode;
        sent = 0;
        while (sent < count) begin
            case ($urandom_range(0, 4))
                0: write_spacing(31'($urandom));
                1: write_spacing(31'($urandom_range(1, 3)));
                default: write_spacing(31'($urandom_range(200, 2000)));
            endcase
            mode = $urandom_range(0, 2);
            send_corner(rand_coord(mode), rand_coord(mode), rand_coord(mode), 1);
            sent++;
            repeat ($urandom_range(3, 12)) begin
                send_corner(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                            $urandom_range(0, 15) == 0);
                sent++;
            end
        end
    endtask

    initial begin
        errors = 0; beats_in = 0; beats_out = 0; clamp_runs = 0;
        corner_x = 0; corner_y = 0; corner_z = 0; spacing_q = 0;
        sink_stall_en = 1; src_stall_en = 1;
        aresetn = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
        cfg_valid = 1'b0; cfg_data = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_passthrough();
        test_directed();
        test_random_paths(260);
        // last stretch at full rate on both sides
        sink_stall_en = 0; src_stall_en = 0;
        test_random_paths(40);
        drain_waypoints();

        $display("covered %0d corners, %0d waypoints, %0d clamped runs",
                 beats_in, beats_out, clamp_runs);
        if (errors == 0 && waypoint_q.size() == 0)
            $display("path_waypoint_densifier test passed");
        else
            $display("path_waypoint_densifier test failed");
        $finish;
    end
endmodule
